/* src/rti_pkg.sv */
// Shared types and constants of the ray/triangle intersection pipeline.
// No dependencies; used by rti_front and ray_triangle_intersection.
package rti_pkg;

	localparam int PT_BITS   = 63;
	localparam int T_FRAC    = 12;
	localparam int EPS_BITS  = 20;
	localparam int ADDR_BITS = 3;
	localparam int DIST_BITS = 31;

	localparam logic [ADDR_BITS-1:0] REG_DET_EPS = 3'd0;
	localparam logic [EPS_BITS-1:0]  EPS_RESET   = 20'd1;

	typedef logic [PT_BITS-1:0] point_t;

endpackage

/* src/rti_front.sv */
// Geometry front end: edges, cross products and dot products, three stages.
// Depends on rti_pkg.
module rti_front #(
	parameter int CW = 21,
	parameter int DW = 69,
	parameter int SW = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  rti_pkg::point_t      origin,
	input  rti_pkg::point_t      direction,
	input  rti_pkg::point_t      v0,
	input  rti_pkg::point_t      v1,
	input  rti_pkg::point_t      v2,
	input  logic [SW-1:0]        side_in,
	output logic                 out_valid,
	output logic signed [DW-1:0] a_out,
	output logic signed [DW-1:0] nu_out,
	output logic signed [DW-1:0] nv_out,
	output logic signed [DW-1:0] nt_out,
	output logic [SW-1:0]        side_out
);
	import rti_pkg::*;

	localparam int EW = CW + 1;
	localparam int HW = 2 * CW + 2;
	localparam int QW = 2 * CW + 3;

	// stage 1: unpack and form edges
	logic signed [CW-1:0] d_c  [3];
	logic signed [EW-1:0] e1_c [3];
	logic signed [EW-1:0] e2_c [3];
	logic signed [EW-1:0] s_c  [3];

	logic signed [CW-1:0] d_s1  [3];
	logic signed [EW-1:0] e1_s1 [3];
	logic signed [EW-1:0] e2_s1 [3];
	logic signed [EW-1:0] s_s1  [3];
	logic [SW-1:0]        side_s1;
	logic                 valid_s1;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			d_c[k]  = $signed(direction[k*CW +: CW]);
			e1_c[k] = EW'($signed(v1[k*CW +: CW])) - EW'($signed(v0[k*CW +: CW]));
			e2_c[k] = EW'($signed(v2[k*CW +: CW])) - EW'($signed(v0[k*CW +: CW]));
			s_c[k]  = EW'($signed(origin[k*CW +: CW])) - EW'($signed(v0[k*CW +: CW]));
		end
	end

	// stage 2: h = d x e2, q = s x e1
	logic signed [CW+EW-1:0] hp_a [3];
	logic signed [CW+EW-1:0] hp_b [3];
	logic signed [2*EW-1:0]  qp_a [3];
	logic signed [2*EW-1:0]  qp_b [3];
	logic signed [HW-1:0]    h_c  [3];
	logic signed [QW-1:0]    q_c  [3];

	logic signed [CW-1:0] d_s2  [3];
	logic signed [EW-1:0] e1_s2 [3];
	logic signed [EW-1:0] e2_s2 [3];
	logic signed [EW-1:0] s_s2  [3];
	logic signed [HW-1:0] h_s2  [3];
	logic signed [QW-1:0] q_s2  [3];
	logic [SW-1:0]        side_s2;
	logic                 valid_s2;

	always_comb begin
		hp_a[0] = d_s1[1] * e2_s1[2];  hp_b[0] = d_s1[2] * e2_s1[1];
		hp_a[1] = d_s1[2] * e2_s1[0];  hp_b[1] = d_s1[0] * e2_s1[2];
		hp_a[2] = d_s1[0] * e2_s1[1];  hp_b[2] = d_s1[1] * e2_s1[0];
		qp_a[0] = s_s1[1] * e1_s1[2];  qp_b[0] = s_s1[2] * e1_s1[1];
		qp_a[1] = s_s1[2] * e1_s1[0];  qp_b[1] = s_s1[0] * e1_s1[2];
		qp_a[2] = s_s1[0] * e1_s1[1];  qp_b[2] = s_s1[1] * e1_s1[0];
		for (int k = 0; k < 3; k++) begin
			h_c[k] = HW'(hp_a[k]) - HW'(hp_b[k]);
			q_c[k] = QW'(qp_a[k]) - QW'(qp_b[k]);
		end
	end

	// stage 3: four dot products
	logic signed [EW+HW-1:0] pa [3];
	logic signed [EW+HW-1:0] pu [3];
	logic signed [CW+QW-1:0] pv [3];
	logic signed [EW+QW-1:0] pt [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			pa[k] = e1_s2[k] * h_s2[k];
			pu[k] = s_s2[k] * h_s2[k];
			pv[k] = d_s2[k] * q_s2[k];
			pt[k] = e2_s2[k] * q_s2[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k]  <= d_c[k];
				e1_s1[k] <= e1_c[k];
				e2_s1[k] <= e2_c[k];
				s_s1[k]  <= s_c[k];
				d_s2[k]  <= d_s1[k];
				e1_s2[k] <= e1_s1[k];
				e2_s2[k] <= e2_s1[k];
				s_s2[k]  <= s_s1[k];
				h_s2[k]  <= h_c[k];
				q_s2[k]  <= q_c[k];
			end
			side_s1  <= side_in;
			side_s2  <= side_s1;
			side_out <= side_s2;
			a_out    <= DW'(pa[0]) + DW'(pa[1]) + DW'(pa[2]);
			nu_out   <= DW'(pu[0]) + DW'(pu[1]) + DW'(pu[2]);
			nv_out   <= DW'(pv[0]) + DW'(pv[1]) + DW'(pv[2]);
			nt_out   <= DW'(pt[0]) + DW'(pt[1]) + DW'(pt[2]);
		end
	end

endmodule

/* src/rti_div.sv */
// Pipelined restoring divider: one quotient bit per register stage.
// No package dependencies.
module rti_div #(
	parameter int DW = 69,
	parameter int NQ = 31,
	parameter int SW = 65
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [DW-1:0] rem_in,
	input  logic [NQ-1:0] low_in,
	input  logic [DW-1:0] den_in,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [NQ-1:0] quo_out,
	output logic [SW-1:0] side_out
);

	logic [DW-1:0] rem_s  [NQ];
	logic [NQ-1:0] low_s  [NQ];
	logic [NQ-1:0] quo_s  [NQ];
	logic [DW-1:0] den_s  [NQ];
	logic [SW-1:0] side_s [NQ];
	logic [NQ-1:0] valid_s;

	logic [DW-1:0] rem_i  [NQ];
	logic [NQ-1:0] low_i  [NQ];
	logic [NQ-1:0] quo_i  [NQ];
	logic [DW-1:0] den_i  [NQ];
	logic [SW-1:0] side_i [NQ];
	logic [NQ-1:0] valid_i;
	logic [DW+1:0] trial  [NQ];
	logic [DW:0]   shifted[NQ];

	always_comb begin
		rem_i[0]   = rem_in;
		low_i[0]   = low_in;
		quo_i[0]   = '0;
		den_i[0]   = den_in;
		side_i[0]  = side_in;
		valid_i[0] = in_valid;
		for (int i = 1; i < NQ; i++) begin
			rem_i[i]   = rem_s[i-1];
			low_i[i]   = low_s[i-1];
			quo_i[i]   = quo_s[i-1];
			den_i[i]   = den_s[i-1];
			side_i[i]  = side_s[i-1];
			valid_i[i] = valid_s[i-1];
		end
		for (int i = 0; i < NQ; i++) begin
			shifted[i] = {rem_i[i], low_i[i][NQ-1]};
			trial[i]   = {1'b0, shifted[i]} - {2'b00, den_i[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= valid_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NQ; i++) begin
				rem_s[i]  <= trial[i][DW+1] ? shifted[i][DW-1:0] : trial[i][DW-1:0];
				quo_s[i]  <= {quo_i[i][NQ-2:0], ~trial[i][DW+1]};
				low_s[i]  <= {low_i[i][NQ-2:0], 1'b0};
				den_s[i]  <= den_i[i];
				side_s[i] <= side_i[i];
			end
		end
	end

	assign out_valid = valid_s[NQ-1];
	assign quo_out   = quo_s[NQ-1];
	assign side_out  = side_s[NQ-1];

endmodule

/* src/ray_triangle_intersection.sv */
// Top level of the ray/triangle intersection pipeline with its APB register.
// Depends on rti_pkg, rti_front and rti_div.
//
// Moller-Trumbore ray/triangle test, fully pipelined: one ray-triangle pair
// is accepted every clock cycle unless the pipe is stalled; a pair passes
// three geometry stages, one test stage, PARAM_BITS - 1 divider stages and
// one output stage; the divider resolves one bit of t per stage.
// Coordinates are signed Q11.10, packed x in the low COORD_BITS bits.
// The determinant and the barycentric numerators are exact; u and v are
// bounded without division, points on an edge count as inside. A pair
// whose |det| is at most det_epsilon (units of 2^-30, register at byte
// address 0, reset 1) is parallel and misses. t is the Q19.12 quotient
// truncated towards zero; a hit needs t > 0, t inside the PARAM_BITS - 1
// bit format and window_low <= t <= window_high. A miss reports distance
// zero. The whole pipe advances together: it holds while a finished
// result beat is stalled, and stall on the input side follows.
module ray_triangle_intersection #(
	parameter int COORD_BITS = 21,
	parameter int PARAM_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rti_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           valid,
	output logic                           stall,
	input  rti_pkg::point_t                ray_origin,
	input  rti_pkg::point_t                ray_direction,
	input  rti_pkg::point_t                vertex_0,
	input  rti_pkg::point_t                vertex_1,
	input  rti_pkg::point_t                vertex_2,
	input  logic signed [31:0]             window_low,
	input  logic signed [31:0]             window_high,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           hit,
	output logic [rti_pkg::DIST_BITS-1:0]  distance
);
	import rti_pkg::*;

	localparam int DW = 3 * COORD_BITS + 6;  // widest dot product, signed
	localparam int NQ = PARAM_BITS - 1;      // quotient bits of t
	localparam int TS = PARAM_BITS - 13;     // t limit as a shift of det
	localparam int LW = DW + TS;
	localparam int SW = 2 * PARAM_BITS;

	logic                en;
	logic [EPS_BITS-1:0] det_eps_q;

	// register port: single read/write register, reads back
	assign pready = 1'b1;
	assign prdata = (paddr == REG_DET_EPS) ? 32'(det_eps_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			det_eps_q <= EPS_RESET;
		end else if (psel && penable && pwrite && paddr == REG_DET_EPS) begin
			det_eps_q <= pwdata[EPS_BITS-1:0];
		end
	end

	// advance unless the output beat is waiting
	assign en    = !(result_valid && result_stall);
	assign stall = !en;

	// geometry: stages 1 to 3
	logic                 v_s3;
	logic signed [DW-1:0] a_s3, nu_s3, nv_s3, nt_s3;
	logic [SW-1:0]        win_s3;

	rti_front #(
		.CW(COORD_BITS),
		.DW(DW),
		.SW(SW)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (valid),
		.origin   (ray_origin),
		.direction(ray_direction),
		.v0       (vertex_0),
		.v1       (vertex_1),
		.v2       (vertex_2),
		.side_in  ({window_low[PARAM_BITS-1:0], window_high[PARAM_BITS-1:0]}),
		.out_valid(v_s3),
		.a_out    (a_s3),
		.nu_out   (nu_s3),
		.nv_out   (nv_s3),
		.nt_out   (nt_s3),
		.side_out (win_s3)
	);

	// stage 4: fold the sign of det into the numerators, then run the tests
	logic signed [DW-1:0] aa, nu_a, nv_a, nt_a;
	logic signed [DW:0]   uv_sum;
	logic signed [LW-1:0] t_lim;
	logic                 ok_c;

	always_comb begin
		if (a_s3 < 0) begin
			aa   = -a_s3;
			nu_a = -nu_s3;
			nv_a = -nv_s3;
			nt_a = -nt_s3;
		end else begin
			aa   = a_s3;
			nu_a = nu_s3;
			nv_a = nv_s3;
			nt_a = nt_s3;
		end
		uv_sum = (DW+1)'(nu_a) + (DW+1)'(nv_a);
		t_lim  = LW'(aa) <<< TS;
		ok_c   = (aa > $signed({1'b0, det_eps_q})) &&
		         (nu_a >= 0) && (nu_a <= aa) &&
		         (nv_a >= 0) && (uv_sum <= (DW+1)'(aa)) &&
		         (nt_a > 0) && (LW'(nt_a) < t_lim);
	end

	logic          v_s4, ok_s4;
	logic [DW-1:0] a_s4, nt_s4;
	logic [SW-1:0] win_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4  <= ok_c;
			a_s4   <= aa;
			nt_s4  <= nt_a;
			win_s4 <= win_s3;
		end
	end

	// divider: (nt << T_FRAC) / det, the top part already below det
	logic              v_dv;
	logic [NQ-1:0]     t_dv;
	logic [SW:0]       side_dv;

	rti_div #(
		.DW(DW),
		.NQ(NQ),
		.SW(SW + 1)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.rem_in   (nt_s4 >> TS),
		.low_in   ({nt_s4[TS-1:0], {T_FRAC{1'b0}}}),
		.den_in   (a_s4),
		.side_in  ({ok_s4, win_s4}),
		.out_valid(v_dv),
		.quo_out  (t_dv),
		.side_out (side_dv)
	);

	// output stage: drop failed tests, zero t and anything outside the window
	logic signed [PARAM_BITS:0] t_x, wl_x, wh_x;
	logic                       hit_c;

	always_comb begin
		t_x   = $signed({2'b00, t_dv});
		wl_x  = (PARAM_BITS+1)'($signed(side_dv[SW-1:PARAM_BITS]));
		wh_x  = (PARAM_BITS+1)'($signed(side_dv[PARAM_BITS-1:0]));
		hit_c = side_dv[SW] && (t_dv != '0) && (t_x >= wl_x) && (t_x <= wh_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit      <= hit_c;
			distance <= hit_c ? DIST_BITS'(t_dv) : '0;
		end
	end

	// a hit always carries a positive distance
	a_hit_dist: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && hit |-> distance != '0)
		else $error("hit with zero distance");

	// a miss always reports zero distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !hit |-> distance == '0)
		else $error("miss with non-zero distance");

	// a register write to the epsilon address lands in the epsilon register
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == REG_DET_EPS
		|=> det_eps_q == $past(pwdata[EPS_BITS-1:0]))
		else $error("epsilon write lost");

endmodule
